FILE: rtl/dhos_pkg.sv
// ---------------------------------------------------------------------------
// dhos_pkg
// Shared types and constants for the detection history outlier smoother.
// ---------------------------------------------------------------------------
package dhos_pkg;

   // Evaluation sequencer states, one-hot.
   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_SCAN   = 12'b000000000010,
      ST_DIVM   = 12'b000000000100,
      ST_DIST   = 12'b000000001000,
      ST_SQRTD  = 12'b000000010000,
      ST_DIVA   = 12'b000000100000,
      ST_DEV    = 12'b000001000000,
      ST_DIVS   = 12'b000010000000,
      ST_SQRTS  = 12'b000100000000,
      ST_KEEP   = 12'b001000000000,
      ST_DIVO   = 12'b010000000000,
      ST_OUT    = 12'b100000000000
   } dhos_state_type;

   // Status handed from the shift-serial divider/root unit.
   typedef struct packed {
      logic busy;
      logic done;
   } dhos_unit_status_type;

   localparam int unsigned SAT_MAX = 16'hFFFF;

endpackage

FILE: rtl/dhos_serial_unit.sv
// ---------------------------------------------------------------------------
// dhos_serial_unit
// Bit-serial restoring divider and integer square root, one result bit
// per cycle, 40-bit operands.
// ---------------------------------------------------------------------------
module dhos_serial_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_sqrt,
   input  logic [39:0] num,
   input  logic [39:0] den,
   output logic [39:0] result,
   output dhos_pkg::dhos_unit_status_type status
);
   logic [39:0] quo_ff, quo_in;
   logic [41:0] rem_ff, rem_in;
   logic [39:0] src_ff, src_in;
   logic [39:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, sq_ff, sq_in;
   logic [41:0] shifted, trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; src_in = src_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; sq_in = sq_ff;
      shifted = '0; trial = '0;
      if (start) begin
         quo_in = '0; rem_in = '0; src_in = num; den_in = den; sq_in = is_sqrt;
         cnt_in = is_sqrt ? 6'd20 : 6'd40; busy_in = 1'b1;
      end else if (busy_ff) begin
         // square root takes two bits a step, division one
         if (sq_ff) begin
            shifted = {rem_ff[39:0], src_ff[39:38]};
            src_in  = {src_ff[37:0], 2'b00};
            trial   = {quo_ff, 2'b01};
         end else begin
            shifted = {rem_ff[40:0], src_ff[39]};
            src_in  = {src_ff[38:0], 1'b0};
            trial   = {2'b00, den_ff};
         end
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; src_ff <= src_in;
      den_ff <= den_in; sq_ff <= sq_in;
   end

   assign result = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

FILE: rtl/detection_history_outlier_smoother_core.sv
// ---------------------------------------------------------------------------
// detection_history_outlier_smoother_core
// Keeps the largest box per frame in a ring history and, at frame end,
// reports the outlier-filtered average box of the window.
// ---------------------------------------------------------------------------
// channel   | dir | payload
// req_      | in  | tdata: blob_present, blob_area, centroid_x/y, box l/t/w/h
//           |     | tlast: end_of_frame
// rsp_      | out | tdata: face_found, face_left/top/width/height
// csr_      | in  | history_length
// An end-of-frame request runs the window sweeps on one shared bit-serial
// unit. At most 8 divisions and MAX_HISTORY + 1 roots are used.
// Reset is synchronous; history starts empty.
// A stalled response holds, and the next request waits for it.
// ---------------------------------------------------------------------------
module detection_history_outlier_smoother_core #(
   parameter int MAX_HISTORY = 16,
   parameter int COORD_BITS  = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // blob_present[0], blob_area[24:1], centroid_x[40:25], centroid_y[56:41],
   // box_left[68:57], box_top[80:69], box_width[92:81], box_height[104:93]
   input  logic [111:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // face_found[0], face_left[16:1], face_top[32:17], face_width[48:33],
   // face_height[64:49]
   output logic [71:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data
);
   localparam int IW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int CW = $clog2(MAX_HISTORY + 1);

   dhos_pkg::dhos_state_type state_ff, state_in;

   logic [4:0]  len_ff;
   logic [MAX_HISTORY-1:0] valid_ff;
   logic [IW-1:0] newest_ff;
   logic [15:0] cx_mem [MAX_HISTORY];
   logic [15:0] cy_mem [MAX_HISTORY];
   logic [COORD_BITS-1:0] bl_mem [MAX_HISTORY];
   logic [COORD_BITS-1:0] bt_mem [MAX_HISTORY];
   logic [COORD_BITS-1:0] bw_mem [MAX_HISTORY];
   logic [COORD_BITS-1:0] bh_mem [MAX_HISTORY];
   logic [39:0] dist_mem [MAX_HISTORY];

   logic        best_has_ff;
   logic [23:0] best_area_ff;
   logic [15:0] best_cx_ff, best_cy_ff;
   logic [11:0] best_l_ff, best_t_ff, best_w_ff, best_h_ff;

   logic [CW-1:0] win_len;
   logic [CW-1:0] step_ff, n_ff, kc_ff;
   logic [1:0]    sub_ff;
   logic [2:0]    oi_ff;
   logic [39:0]   acc0_ff, acc1_ff;
   logic [39:0]   sl_ff, st_ff, sw_ff, sh_ff;
   logic [39:0]   mx_ff, my_ff, avg_ff, sig3_ff;
   logic [15:0]   res_ff [4];
   logic          found_ff, rsp_valid_ff;

   logic          u_start, u_sqrt;
   logic [39:0]   u_num, u_den, u_res;
   dhos_pkg::dhos_unit_status_type u_stat;

   logic [IW-1:0] slot, next_slot;
   logic          acc_req, push, take;
   logic [23:0]   in_area;
   logic [15:0]   ddx, ddy;
   logic [31:0]   sqx, sqy;
   logic [16:0]   dev;
   logic [33:0]   devsq;

   dhos_serial_unit u_unit (
      .clock(clock), .reset(reset), .start(u_start), .is_sqrt(u_sqrt),
      .num(u_num), .den(u_den), .result(u_res), .status(u_stat)
   );

   // absolute difference helper inputs
   function automatic logic [39:0] absd(input logic [39:0] a, input logic [39:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   assign in_area = req_tdata[24:1];
   assign win_len = (len_ff == 5'd0) ? CW'(1) :
                    (32'(len_ff) > MAX_HISTORY) ? CW'(MAX_HISTORY) : CW'(len_ff);
   assign req_tready = (state_ff == dhos_pkg::ST_IDLE) && !rsp_valid_ff;
   assign acc_req = req_tvalid && req_tready;
   assign push = acc_req && req_tlast;
   assign take = acc_req && req_tdata[0] && (!best_has_ff || in_area > best_area_ff);
   // ring slot after newest, and slot walked back from newest
   assign next_slot = (32'(newest_ff) == MAX_HISTORY - 1) ? '0 : IW'(32'(newest_ff) + 1);
   assign slot = (32'(newest_ff) >= 32'(step_ff)) ?
                 IW'(32'(newest_ff) - 32'(step_ff)) :
                 IW'(32'(newest_ff) + MAX_HISTORY - 32'(step_ff));

   // squared centroid distance and squared deviation of the current slot
   assign ddx   = 16'(absd(40'(cx_mem[slot]), mx_ff));
   assign ddy   = 16'(absd(40'(cy_mem[slot]), my_ff));
   assign sqx   = ddx * ddx;
   assign sqy   = ddy * ddy;
   assign dev   = 17'(absd(dist_mem[slot], avg_ff));
   assign devsq = dev * dev;

   always_comb begin
      u_start = 1'b0; u_sqrt = 1'b0; u_num = '0; u_den = 40'd1;
      state_in = state_ff;
      unique case (state_ff)
         dhos_pkg::ST_IDLE:  if (push) state_in = dhos_pkg::ST_SCAN;
         dhos_pkg::ST_SCAN:  if (step_ff == win_len) state_in = dhos_pkg::ST_DIVM;
         dhos_pkg::ST_DIVM: begin
            if (n_ff == '0 || 32'(n_ff) < 32'(win_len) / 2 || n_ff == CW'(1))
               state_in = dhos_pkg::ST_DIVO;
            else if (!u_stat.busy && !u_stat.done) begin
               u_start = 1'b1; u_num = (sub_ff == 2'd0) ? acc0_ff : acc1_ff;
               u_den = 40'(n_ff);
            end
            if (u_stat.done && sub_ff == 2'd1) state_in = dhos_pkg::ST_DIST;
         end
         dhos_pkg::ST_DIST: begin
            if (step_ff == win_len) state_in = dhos_pkg::ST_DIVA;
            else if (valid_ff[slot] && !u_stat.busy && !u_stat.done) begin
               u_start = 1'b1; u_sqrt = 1'b1;
               u_num = 40'(sqx) + 40'(sqy);
            end
         end
         dhos_pkg::ST_DIVA: begin
            if (!u_stat.busy && !u_stat.done) begin
               u_start = 1'b1; u_num = acc0_ff; u_den = 40'(n_ff);
            end
            if (u_stat.done) state_in = dhos_pkg::ST_DEV;
         end
         dhos_pkg::ST_DEV:  if (step_ff == win_len) state_in = dhos_pkg::ST_DIVS;
         dhos_pkg::ST_DIVS: begin
            if (!u_stat.busy && !u_stat.done) begin
               u_start = 1'b1; u_num = acc1_ff; u_den = 40'(n_ff);
            end
            if (u_stat.done) state_in = dhos_pkg::ST_SQRTS;
         end
         dhos_pkg::ST_SQRTS: begin
            if (sub_ff == 2'd0) begin
               u_start = 1'b1; u_sqrt = 1'b1; u_num = acc1_ff;
            end
            if (u_stat.done) state_in = dhos_pkg::ST_KEEP;
         end
         dhos_pkg::ST_KEEP: if (step_ff == win_len) state_in = dhos_pkg::ST_DIVO;
         dhos_pkg::ST_DIVO: begin
            if (!found_ff || oi_ff == 3'd4) state_in = dhos_pkg::ST_OUT;
            else if (!u_stat.busy && !u_stat.done) begin
               u_start = 1'b1; u_den = 40'(kc_ff);
               case (oi_ff[1:0])
                  2'd0: u_num = {sl_ff[35:0], 4'd0};
                  2'd1: u_num = {st_ff[35:0], 4'd0};
                  2'd2: u_num = {sw_ff[35:0], 4'd0};
                  default: u_num = {sh_ff[35:0], 4'd0};
               endcase
            end
         end
         dhos_pkg::ST_OUT:   state_in = dhos_pkg::ST_IDLE;
         default:            state_in = dhos_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dhos_pkg::ST_IDLE;
         len_ff <= 5'd16;
         valid_ff <= '0;
         newest_ff <= '0;
         best_has_ff <= 1'b0;
         best_area_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
            valid_ff <= '0;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         // best box of the frame, box on last item also competes before the push
         if (acc_req) begin
            if (push) begin
               best_has_ff <= 1'b0; best_area_ff <= '0;
               newest_ff <= next_slot;
               valid_ff[next_slot] <= take || best_has_ff;
            end else if (take) begin
               best_has_ff <= 1'b1; best_area_ff <= in_area;
            end
         end
         if (state_ff == dhos_pkg::ST_OUT) rsp_valid_ff <= 1'b1;
      end
      if (take) begin
         best_cx_ff <= req_tdata[40:25]; best_cy_ff <= req_tdata[56:41];
         best_l_ff <= req_tdata[68:57]; best_t_ff <= req_tdata[80:69];
         best_w_ff <= req_tdata[92:81]; best_h_ff <= req_tdata[104:93];
      end
      if (push) begin
         cx_mem[next_slot] <= take ? req_tdata[40:25] : best_cx_ff;
         cy_mem[next_slot] <= take ? req_tdata[56:41] : best_cy_ff;
         bl_mem[next_slot] <= COORD_BITS'(take ? req_tdata[68:57] : best_l_ff);
         bt_mem[next_slot] <= COORD_BITS'(take ? req_tdata[80:69] : best_t_ff);
         bw_mem[next_slot] <= COORD_BITS'(take ? req_tdata[92:81] : best_w_ff);
         bh_mem[next_slot] <= COORD_BITS'(take ? req_tdata[104:93] : best_h_ff);
         step_ff <= '0; n_ff <= '0; acc0_ff <= '0; acc1_ff <= '0; sub_ff <= '0;
      end
      // evaluation datapath
      case (state_ff)
         dhos_pkg::ST_SCAN: if (step_ff != win_len) begin
            step_ff <= step_ff + CW'(1);
            if (valid_ff[slot]) begin
               n_ff <= n_ff + CW'(1);
               acc0_ff <= acc0_ff + 40'(cx_mem[slot]);
               acc1_ff <= acc1_ff + 40'(cy_mem[slot]);
               sl_ff <= 40'(bl_mem[slot]); st_ff <= 40'(bt_mem[slot]);
               sw_ff <= 40'(bw_mem[slot]); sh_ff <= 40'(bh_mem[slot]);
            end
         end else begin
            step_ff <= '0; kc_ff <= CW'(1); oi_ff <= '0;
            found_ff <= !(n_ff == '0 || 32'(n_ff) < 32'(win_len) / 2);
         end
         dhos_pkg::ST_DIVM: if (u_stat.done) begin
            if (sub_ff == 2'd0) begin mx_ff <= u_res; sub_ff <= 2'd1; end
            else begin
               my_ff <= u_res; sub_ff <= 2'd0; acc0_ff <= '0; step_ff <= '0;
               sl_ff <= '0; st_ff <= '0; sw_ff <= '0; sh_ff <= '0; kc_ff <= '0;
            end
         end
         dhos_pkg::ST_DIST: begin
            // one root per valid slot, distance stored when it finishes
            if (step_ff != win_len) begin
               if (!valid_ff[slot]) step_ff <= step_ff + CW'(1);
               else if (u_stat.done) begin
                  dist_mem[slot] <= u_res;
                  acc0_ff <= acc0_ff + u_res;
                  step_ff <= step_ff + CW'(1);
               end
            end else begin
               step_ff <= '0; acc1_ff <= '0;
            end
         end
         dhos_pkg::ST_DIVA: if (u_stat.done) avg_ff <= u_res;
         dhos_pkg::ST_DEV: if (step_ff != win_len) begin
            step_ff <= step_ff + CW'(1);
            if (valid_ff[slot])
               acc1_ff <= acc1_ff + 40'(devsq);
         end else step_ff <= '0;
         dhos_pkg::ST_DIVS: if (u_stat.done) begin acc1_ff <= u_res; sub_ff <= 2'd0; end
         dhos_pkg::ST_SQRTS: begin
            sub_ff <= 2'd1;
            if (u_stat.done) sig3_ff <= u_res * 40'd3;
         end
         dhos_pkg::ST_KEEP: if (step_ff != win_len) begin
            step_ff <= step_ff + CW'(1);
            if (valid_ff[slot] && dist_mem[slot] < sig3_ff) begin
               kc_ff <= kc_ff + CW'(1);
               sl_ff <= sl_ff + 40'(bl_mem[slot]); st_ff <= st_ff + 40'(bt_mem[slot]);
               sw_ff <= sw_ff + 40'(bw_mem[slot]); sh_ff <= sh_ff + 40'(bh_mem[slot]);
            end
         end else found_ff <= (kc_ff != '0);
         dhos_pkg::ST_DIVO: if (u_stat.done) begin
            res_ff[oi_ff[1:0]] <= (u_res > 40'(dhos_pkg::SAT_MAX)) ? 16'hFFFF : u_res[15:0];
            oi_ff <= oi_ff + 3'd1;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        found_ff ? res_ff[3] : 16'd0, found_ff ? res_ff[2] : 16'd0,
                        found_ff ? res_ff[1] : 16'd0, found_ff ? res_ff[0] : 16'd0,
                        found_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != dhos_pkg::ST_IDLE |-> !req_tready)
      else $error("request taken during evaluation");
   a_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == dhos_pkg::ST_OUT |=> rsp_tvalid)
      else $error("evaluation end without response");
endmodule
